// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the mip chain block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfmc_pkg.sv =====
// Shared constants, types and channel arithmetic of the box filter mip chain.
`default_nettype none

package bfmc_pkg;

    localparam int MAX_WIDTH_LOG2 = 12;
    localparam int MAX_LEVELS     = 12;

    localparam int COORD_W    = MAX_WIDTH_LOG2;
    localparam int LINE_DEPTH = 1 << MAX_WIDTH_LOG2;
    localparam int LINE_AW    = MAX_WIDTH_LOG2;
    localparam int LEVEL_N    = MAX_LEVELS + 1;
    localparam int LEVEL_W    = $clog2(LEVEL_N);

    localparam int EXP_W      = 4;
    localparam int OUT_LVL_W  = 4;
    localparam int CHAN_N     = 4;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = CHAN_N * CHAN_W;
    localparam int SUM_W      = CHAN_W + 1;
    localparam int PAIR_W     = CHAN_N * SUM_W;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
    localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
    localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

    localparam logic [EXP_W-1:0] WIDTH_LOG2_RST  = EXP_W'(8);
    localparam logic [EXP_W-1:0] HEIGHT_LOG2_RST = EXP_W'(8);
    localparam logic [EXP_W-1:0] LEVEL_COUNT_RST = EXP_W'(0);

    typedef struct packed {
        logic [EXP_W-1:0] width_log2;
        logic [EXP_W-1:0] height_log2;
        logic [EXP_W-1:0] level_count;
    } cfg_t;

    typedef struct packed {
        logic load_in;   // latch a base pixel, start at level 0
        logic step;      // run one level: advance its position, store or read
        logic emit;      // finish a reduced pixel into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic cascade;   // current level completes a pixel of the next level
        logic out_busy;  // output register holds a beat not yet taken
    } dp_stat_t;

    function automatic logic [PAIR_W-1:0] pair_add(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PAIR_W-1:0] s;
        s = '0;
        for (int i = 0; i < CHAN_N; i++) begin
            s[i*SUM_W +: SUM_W] = SUM_W'(a[i*CHAN_W +: CHAN_W]) +
                                  SUM_W'(b[i*CHAN_W +: CHAN_W]);
        end
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] box_average(input logic [PAIR_W-1:0] top,
                                                     input logic [PAIR_W-1:0] bot);
        logic [PIX_W-1:0] v;
        logic [SUM_W:0]   t;
        v = '0;
        for (int i = 0; i < CHAN_N; i++) begin
            t = (SUM_W+1)'(top[i*SUM_W +: SUM_W]) + (SUM_W+1)'(bot[i*SUM_W +: SUM_W]);
            v[i*CHAN_W +: CHAN_W] = t[SUM_W:2];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfmc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bfmc_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfmc_regs.sv =====
// APB configuration registers of the mip chain: image size and level count.
`default_nettype none

module bfmc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bfmc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bfmc_pkg::DATA_W-1:0]   pwdata,
    output logic      [bfmc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output bfmc_pkg::cfg_t                     cfg,
    output logic                               cfg_wr
);

    bfmc_pkg::cfg_t   cfg_reg;
    bfmc_pkg::cfg_t   cfg_next;
    logic [1:0]       reg_idx;
    logic             wr_sel;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_sel  = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // only a write that hits a register restarts the image
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_wr   = 1'b0;
        if (wr_sel)
        begin
            unique case (reg_idx)
                bfmc_pkg::REG_WIDTH_LOG2:
                begin
                    cfg_next.width_log2 = pwdata[bfmc_pkg::EXP_W-1:0];
                    cfg_wr              = 1'b1;
                end
                bfmc_pkg::REG_HEIGHT_LOG2:
                begin
                    cfg_next.height_log2 = pwdata[bfmc_pkg::EXP_W-1:0];
                    cfg_wr               = 1'b1;
                end
                bfmc_pkg::REG_LEVEL_COUNT:
                begin
                    cfg_next.level_count = pwdata[bfmc_pkg::EXP_W-1:0];
                    cfg_wr               = 1'b1;
                end
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bfmc_pkg::REG_WIDTH_LOG2:
                prdata = bfmc_pkg::DATA_W'(cfg_reg.width_log2);
            bfmc_pkg::REG_HEIGHT_LOG2:
                prdata = bfmc_pkg::DATA_W'(cfg_reg.height_log2);
            bfmc_pkg::REG_LEVEL_COUNT:
                prdata = bfmc_pkg::DATA_W'(cfg_reg.level_count);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_log2  <= bfmc_pkg::WIDTH_LOG2_RST;
            cfg_reg.height_log2 <= bfmc_pkg::HEIGHT_LOG2_RST;
            cfg_reg.level_count <= bfmc_pkg::LEVEL_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfmc_ctrl.sv =====
// Sequencer of the mip chain: walks one base pixel up through the levels.
`default_nettype none

module bfmc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bfmc_pkg::dp_stat_t   stat,
    output bfmc_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.cascade ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                // line data waits in the RAM output until the output register frees
                if (!stat.out_busy)
                begin
                    // the next level always advances its position with the new pixel
                    cmd.emit   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfmc_datapath.sv =====
// Datapath of the mip chain: level positions, held pixels, pair-sum line store, output.
`default_nettype none

module bfmc_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bfmc_pkg::cfg_t                    cfg,
    input  wire logic                              cfg_wr,
    input  wire bfmc_pkg::dp_cmd_t                 cmd,
    output bfmc_pkg::dp_stat_t                     stat,
    input  wire logic [bfmc_pkg::PIX_W-1:0]        base_pixel,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [bfmc_pkg::OUT_LVL_W-1:0]    mip_level,
    output logic      [bfmc_pkg::PIX_W-1:0]        mip_pixel,
    output logic                                   run_last,
    output logic                                   chain_done
);

    localparam int CW  = bfmc_pkg::COORD_W;
    localparam int EW  = bfmc_pkg::EXP_W;
    localparam int LW  = bfmc_pkg::LEVEL_W;

    logic [bfmc_pkg::PIX_W-1:0]   p_reg;
    logic [LW-1:0]                k_reg;
    logic [bfmc_pkg::PAIR_W-1:0]  s_reg;
    logic [CW-1:0]                col_reg  [bfmc_pkg::LEVEL_N];
    logic [CW-1:0]                row_reg  [bfmc_pkg::LEVEL_N];
    logic [bfmc_pkg::PIX_W-1:0]   held_reg [bfmc_pkg::LEVEL_N];

    logic                         out_valid_reg;
    logic [bfmc_pkg::OUT_LVL_W-1:0] out_level_reg;
    logic [bfmc_pkg::PIX_W-1:0]   out_pixel_reg;
    logic                         out_last_reg;
    logic                         out_done_reg;

    logic [EW-1:0]                wl;
    logic [EW-1:0]                hl;
    logic [EW-1:0]                lc;
    logic [EW-1:0]                min_wh;
    logic [EW-1:0]                levels_e;
    logic [LW-1:0]                levels;

    logic [CW-1:0]                c;
    logic [CW-1:0]                r;
    logic [CW:0]                  wk;
    logic [CW:0]                  hk;
    logic [CW:0]                  c_inc;
    logic [CW:0]                  r_inc;
    logic                         col_wrap;
    logic                         row_wrap;
    logic                         active;
    logic                         cascade;
    logic [bfmc_pkg::PAIR_W-1:0]  pair;
    logic [CW:0]                  idx_full;
    logic [bfmc_pkg::LINE_AW-1:0] line_idx;

    logic [LW-1:0]                kn;
    logic [LW-1:0]                kn_idx;
    logic [CW:0]                  wkn;
    logic [CW:0]                  hkn;
    logic                         more;
    logic                         done_now;
    logic [bfmc_pkg::PIX_W-1:0]   avg;

    logic                         ram_wr;
    logic                         ram_rd;
    logic [bfmc_pkg::PAIR_W-1:0]  ram_q;

    // effective image exponents and level count
    always_comb
    begin
        wl = (cfg.width_log2 > EW'(bfmc_pkg::MAX_WIDTH_LOG2)) ?
             EW'(bfmc_pkg::MAX_WIDTH_LOG2) : cfg.width_log2;
        hl = (cfg.height_log2 > EW'(bfmc_pkg::MAX_WIDTH_LOG2)) ?
             EW'(bfmc_pkg::MAX_WIDTH_LOG2) : cfg.height_log2;
        lc = (cfg.level_count > EW'(bfmc_pkg::MAX_LEVELS)) ?
             EW'(bfmc_pkg::MAX_LEVELS) : cfg.level_count;
        min_wh   = (wl < hl) ? wl : hl;
        levels_e = (lc < min_wh) ? lc : min_wh;
        levels   = LW'(levels_e);
    end

    // current level
    always_comb
    begin
        c        = col_reg[k_reg];
        r        = row_reg[k_reg];
        wk       = (CW+1)'(1) << (wl - EW'(k_reg));
        hk       = (CW+1)'(1) << (hl - EW'(k_reg));
        c_inc    = (CW+1)'(c) + (CW+1)'(1);
        r_inc    = (CW+1)'(r) + (CW+1)'(1);
        col_wrap = (c_inc >= wk);
        row_wrap = (r_inc >= hk);
        active   = (k_reg < levels);
        cascade  = active & c[0] & r[0];
        pair     = bfmc_pkg::pair_add(held_reg[k_reg], p_reg);
        // line of level k starts after the lines of all lower levels
        idx_full = ((CW+1)'(1) << wl) - wk + (CW+1)'(c >> 1);
        line_idx = idx_full[bfmc_pkg::LINE_AW-1:0];
    end

    // level the pixel being finished belongs to
    always_comb
    begin
        kn     = k_reg + LW'(1);
        kn_idx = (kn > LW'(bfmc_pkg::MAX_LEVELS)) ? LW'(bfmc_pkg::MAX_LEVELS) : kn;
        wkn    = (CW+1)'(1) << (wl - EW'(kn));
        hkn    = (CW+1)'(1) << (hl - EW'(kn));
        more   = (kn < levels) & col_reg[kn_idx][0] & row_reg[kn_idx][0];
        done_now = (kn == levels) &&
                   ((CW+1)'(col_reg[kn_idx]) == wkn - (CW+1)'(1)) &&
                   ((CW+1)'(row_reg[kn_idx]) == hkn - (CW+1)'(1));
        avg    = bfmc_pkg::box_average(ram_q, s_reg);
    end

    assign ram_wr = cmd.step & active & c[0] & ~r[0];
    assign ram_rd = cmd.step & cascade;

    bfmc_ram #(
        .WIDTH (bfmc_pkg::PAIR_W),
        .DEPTH (bfmc_pkg::LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (line_idx),
        .wr_data (pair),
        .rd_en   (ram_rd),
        .rd_addr (line_idx),
        .rd_data (ram_q)
    );

    assign stat = '{cascade: cascade, out_busy: out_valid_reg & ~out_ready};

    // level positions; a configuration write starts a new image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfmc_pkg::LEVEL_N; i++)
            begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
            k_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                for (int i = 0; i < bfmc_pkg::LEVEL_N; i++)
                begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                end
            end
            else if (cmd.step)
            begin
                if (col_wrap)
                begin
                    col_reg[k_reg] <= '0;
                    row_reg[k_reg] <= row_wrap ? '0 : r_inc[CW-1:0];
                end
                else
                begin
                    col_reg[k_reg] <= c_inc[CW-1:0];
                end
            end

            if (cmd.load_in)
            begin
                k_reg <= '0;
            end
            else if (cmd.emit)
            begin
                k_reg <= kn;
            end
        end
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            p_reg <= base_pixel;
        end
        else if (cmd.emit)
        begin
            p_reg <= avg;
        end

        if (cmd.step && cascade)
        begin
            s_reg <= pair;
        end

        if (cmd.step && active && !c[0])
        begin
            held_reg[k_reg] <= p_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_level_reg <= bfmc_pkg::OUT_LVL_W'(kn);
            out_pixel_reg <= avg;
            out_last_reg  <= ~more;
            out_done_reg  <= done_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mip_level  = out_level_reg;
    assign mip_pixel  = out_pixel_reg;
    assign run_last   = out_last_reg;
    assign chain_done = out_done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/box_filter_mipmap_chain_core.sv =====
// Top level of the streaming 2x2 box filter mip chain generator.
//
// Input channel: base_pixel beats (four 8-bit channels), raster order over a
// 2^width_log2 by 2^height_log2 image; in_ready is high only while no pixel
// is in flight.
// Output channel: one beat per reduced pixel (mip_level, mip_pixel); run_last
// marks the last beat caused by one base pixel, chain_done the final pixel of
// the final level. Several levels finished by one pixel come lowest first.
// Sequence: a base pixel is loaded in the idle state, then steps level 0; each
// reduced pixel adds a read state, which puts its average into the output
// register, and a step of the next level. The walk goes level by level with
// a registered line store read.
// A stalled receiver holds the output register; the next level waits with its
// line data parked at the RAM output until the beat is taken.
// Reset: registers return to width 8, height 8, level count 0 (no output);
// all level positions restart at zero. A write to any of the three registers
// also restarts the positions, so a new image begins. The line store needs no clearing.
`default_nettype none

module box_filter_mipmap_chain_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bfmc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [bfmc_pkg::DATA_W-1:0]       pwdata,
    output logic      [bfmc_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bfmc_pkg::PIX_W-1:0]        base_pixel,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [bfmc_pkg::OUT_LVL_W-1:0]    mip_level,
    output logic      [bfmc_pkg::PIX_W-1:0]        mip_pixel,
    output logic                                   run_last,
    output logic                                   chain_done
);

    bfmc_pkg::cfg_t     cfg;
    logic               cfg_wr;
    bfmc_pkg::dp_cmd_t  cmd;
    bfmc_pkg::dp_stat_t stat;

    bfmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    bfmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfmc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_wr     (cfg_wr),
        .cmd        (cmd),
        .stat       (stat),
        .base_pixel (base_pixel),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .mip_level  (mip_level),
        .mip_pixel  (mip_pixel),
        .run_last   (run_last),
        .chain_done (chain_done)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bfmc_checker.sv =====
// Port-level checker of the mip chain core and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module bfmc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [bfmc_pkg::OUT_LVL_W-1:0]    mip_level,
    input wire logic [bfmc_pkg::PIX_W-1:0]        mip_pixel,
    input wire logic                              run_last,
    input wire logic                              chain_done
);

    // a stalled result beat keeps its pixel, level and run_last
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mip_pixel) && $stable(mip_level) && $stable(run_last), "stalled output beat changed")

    // the final pixel of the chain ends its run
    `ASSERT_IMPLY(a_done_last, out_valid && chain_done, run_last, "chain_done without run_last")

    // reduced levels are numbered from one up to the maximum
    `ASSERT_IMPLY(a_level_range, out_valid, mip_level != '0 && mip_level <= bfmc_pkg::OUT_LVL_W'(bfmc_pkg::MAX_LEVELS), "mip_level out of range")

    // a pixel taken on the input keeps in_ready low in the next cycle
    `ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

endmodule

bind box_filter_mipmap_chain_core bfmc_checker u_bfmc_checker (.*);

`default_nettype wire

// ===== tb/box_filter_mipmap_chain_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 2x2 box filter mip chain core.
module box_filter_mipmap_chain_core_tb;

    // paddr[3:2] value that maps to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 32;

    typedef struct packed {
        logic [bfmc_pkg::OUT_LVL_W-1:0] level;
        logic [bfmc_pkg::PIX_W-1:0]     pixel;
        logic                           last;
        logic                           done;
    } mip_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bfmc_pkg::ADDR_W-1:0]     paddr;
    logic [bfmc_pkg::DATA_W-1:0]     pwdata;
    logic [bfmc_pkg::DATA_W-1:0]     prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic [bfmc_pkg::PIX_W-1:0]      base_pixel;
    logic                            out_valid;
    logic                            out_ready;
    logic [bfmc_pkg::OUT_LVL_W-1:0]  mip_level;
    logic [bfmc_pkg::PIX_W-1:0]      mip_pixel;
    logic                            run_last;
    logic                            chain_done;

    // predictor state
    logic [bfmc_pkg::PAIR_W-1:0]     row_pair_sums [0:bfmc_pkg::LINE_DEPTH-1];
    logic [bfmc_pkg::PIX_W-1:0]      left_pixels [0:bfmc_pkg::MAX_LEVELS];
    int unsigned                     col_pos [0:bfmc_pkg::MAX_LEVELS];
    int unsigned                     row_pos [0:bfmc_pkg::MAX_LEVELS];
    logic [bfmc_pkg::EXP_W-1:0]      cfg_width_log2;
    logic [bfmc_pkg::EXP_W-1:0]      cfg_height_log2;
    logic [bfmc_pkg::EXP_W-1:0]      cfg_level_count;

    mip_beat_t             expected_mip_beats [$];

    int unsigned           fail_count;
    int unsigned           pixels_sent;
    int unsigned           beats_predicted;
    int unsigned           beats_checked;
    int unsigned           reg_writes;
    int unsigned           stall_left;
    bit                    in_idle_on;
    bit                    out_stall_on;
    bit                    on_fall_edge;

    box_filter_mipmap_chain_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_pixel (base_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mip_level  (mip_level),
        .mip_pixel  (mip_pixel),
        .run_last   (run_last),
        .chain_done (chain_done)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic logic [bfmc_pkg::PIX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    function automatic logic [bfmc_pkg::PAIR_W-1:0] sum_pair(
        input logic [bfmc_pkg::PIX_W-1:0] a,
        input logic [bfmc_pkg::PIX_W-1:0] b);
        logic [bfmc_pkg::PAIR_W-1:0] s;
        s = '0;
        for (int ch = 0; ch < bfmc_pkg::CHAN_N; ch++)
            s[ch*bfmc_pkg::SUM_W +: bfmc_pkg::SUM_W] =
                {1'b0, a[ch*bfmc_pkg::CHAN_W +: bfmc_pkg::CHAN_W]} +
                {1'b0, b[ch*bfmc_pkg::CHAN_W +: bfmc_pkg::CHAN_W]};
        return s;
    endfunction

    function automatic logic [bfmc_pkg::PIX_W-1:0] average_quad(
        input logic [bfmc_pkg::PAIR_W-1:0] upper,
        input logic [bfmc_pkg::PAIR_W-1:0] lower);
        logic [bfmc_pkg::PIX_W-1:0] v;
        logic [bfmc_pkg::SUM_W:0]   total;
        v = '0;
        for (int ch = 0; ch < bfmc_pkg::CHAN_N; ch++)
        begin
            total = {1'b0, upper[ch*bfmc_pkg::SUM_W +: bfmc_pkg::SUM_W]} +
                    {1'b0, lower[ch*bfmc_pkg::SUM_W +: bfmc_pkg::SUM_W]};
            v[ch*bfmc_pkg::CHAN_W +: bfmc_pkg::CHAN_W] = total[bfmc_pkg::SUM_W:2];
        end
        return v;
    endfunction

    task automatic restart_positions();
        for (int lv = 0; lv <= bfmc_pkg::MAX_LEVELS; lv++)
        begin
            col_pos[lv] = 0;
            row_pos[lv] = 0;
        end
    endtask

    // Walk the pixel up the chain, queueing every reduced pixel it completes.
    task automatic predict_mip_results(input logic [bfmc_pkg::PIX_W-1:0] pix);
        int unsigned wl;
        int unsigned hl;
        int unsigned levels;
        int unsigned k;
        int unsigned c;
        int unsigned r;
        int unsigned wk;
        int unsigned hk;
        int unsigned idx;
        logic [bfmc_pkg::PAIR_W-1:0] hsum;
        logic [bfmc_pkg::PIX_W-1:0]  cur;
        mip_beat_t         beat;
        bit                have_beat;
        bit                halt;
        wl = (cfg_width_log2 > bfmc_pkg::MAX_WIDTH_LOG2) ?
             bfmc_pkg::MAX_WIDTH_LOG2 : cfg_width_log2;
        hl = (cfg_height_log2 > bfmc_pkg::MAX_WIDTH_LOG2) ?
             bfmc_pkg::MAX_WIDTH_LOG2 : cfg_height_log2;
        levels = (cfg_level_count > bfmc_pkg::MAX_LEVELS) ?
                 bfmc_pkg::MAX_LEVELS : cfg_level_count;
        if (levels > wl)
            levels = wl;
        if (levels > hl)
            levels = hl;
        cur = pix;
        k = 0;
        have_beat = 0;
        halt = 0;
        beat = '0;
        while (!halt)
        begin
            c = col_pos[k];
            r = row_pos[k];
            wk = 32'd1 << (wl - k);
            hk = 32'd1 << (hl - k);
            if (c + 1 >= wk)
            begin
                col_pos[k] = 0;
                row_pos[k] = (r + 1 >= hk) ? 0 : r + 1;
            end
            else
                col_pos[k] = c + 1;
            if (k >= levels)
                halt = 1;
            else if ((c & 1) == 0)
            begin
                left_pixels[k] = cur;
                halt = 1;
            end
            else
            begin
                idx = ((32'd1 << wl) - wk + (c >> 1)) % bfmc_pkg::LINE_DEPTH;
                hsum = sum_pair(left_pixels[k], cur);
                if ((r & 1) == 0)
                begin
                    row_pair_sums[idx] = hsum;
                    halt = 1;
                end
                else
                begin
                    cur = average_quad(row_pair_sums[idx], hsum);
                    k++;
                    if (have_beat)
                        expected_mip_beats.push_back(beat);
                    beat.level = bfmc_pkg::OUT_LVL_W'(k);
                    beat.pixel = cur;
                    beat.last = 1'b0;
                    beat.done = (k == levels &&
                                 col_pos[k] == (32'd1 << (wl - k)) - 1 &&
                                 row_pos[k] == (32'd1 << (hl - k)) - 1);
                    have_beat = 1;
                    beats_predicted++;
                end
            end
        end
        if (have_beat)
        begin
            beat.last = 1'b1;
            expected_mip_beats.push_back(beat);
        end
    endtask

    // Check every beat taken on the output channel.
    always @(posedge clk)
    begin
        mip_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_mip_beats.size() == 0)
            begin
                $error("unexpected beat: level %0d pixel %08h", mip_level, mip_pixel);
                fail_count++;
            end
            else
            begin
                e = expected_mip_beats.pop_front();
                beats_checked++;
                if (mip_level !== e.level)
                begin
                    $error("mip_level: expected %0d, got %0d", e.level, mip_level);
                    fail_count++;
                end
                if (mip_pixel !== e.pixel)
                begin
                    $error("mip_pixel: expected %08h, got %08h", e.pixel, mip_pixel);
                    fail_count++;
                end
                if (run_last !== e.last)
                begin
                    $error("run_last: expected %0b, got %0b", e.last, run_last);
                    fail_count++;
                end
                if (chain_done !== e.done)
                begin
                    $error("chain_done: expected %0b, got %0b", e.done, chain_done);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_stall_on)
                stall_left = pick_gap();
        end
    end

    task automatic push_base_pixel(input logic [bfmc_pkg::PIX_W-1:0] pix);
        int unsigned gap;
        if (!on_fall_edge)
            @(negedge clk);
        in_valid <= 1'b1;
        base_pixel <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
        predict_mip_results(pix);
        @(negedge clk);
        gap = in_idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        on_fall_edge = 1;
    endtask

    task automatic push_random_pixels(input int unsigned count);
        repeat (count) push_base_pixel(pick_pixel());
    endtask

    // Drop valid, drain every expected beat, then let a pixel with no result finish.
    task automatic quiesce();
        if (on_fall_edge)
        begin
            in_valid <= 1'b0;
            on_fall_edge = 0;
        end
        while (expected_mip_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [bfmc_pkg::EXP_W-1:0] value);
        quiesce();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= bfmc_pkg::DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            bfmc_pkg::REG_WIDTH_LOG2:  cfg_width_log2 = value;
            bfmc_pkg::REG_HEIGHT_LOG2: cfg_height_log2 = value;
            bfmc_pkg::REG_LEVEL_COUNT: cfg_level_count = value;
            default: ;
        endcase
        if (idx != REG_UNUSED)
            restart_positions();
        reg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx,
                             input logic [bfmc_pkg::EXP_W-1:0] value);
        quiesce();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== bfmc_pkg::DATA_W'(value))
        begin
            $error("prdata reg %0d: expected %0h, got %0h", idx, value, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_image(input logic [bfmc_pkg::EXP_W-1:0] wl,
                             input logic [bfmc_pkg::EXP_W-1:0] hl,
                             input logic [bfmc_pkg::EXP_W-1:0] lc);
        write_reg(bfmc_pkg::REG_WIDTH_LOG2, wl);
        write_reg(bfmc_pkg::REG_HEIGHT_LOG2, hl);
        write_reg(bfmc_pkg::REG_LEVEL_COUNT, lc);
    endtask

    // Mipmapping is off out of reset: pixels flow in, nothing comes out.
    task automatic test_power_on_defaults();
        check_reg(bfmc_pkg::REG_WIDTH_LOG2, bfmc_pkg::WIDTH_LOG2_RST);
        check_reg(bfmc_pkg::REG_HEIGHT_LOG2, bfmc_pkg::HEIGHT_LOG2_RST);
        check_reg(bfmc_pkg::REG_LEVEL_COUNT, bfmc_pkg::LEVEL_COUNT_RST);
        push_base_pixel(32'h0000_0000);
        push_base_pixel(32'hFFFF_FFFF);
        push_base_pixel(32'hAAAA_AAAA);
        push_base_pixel(32'h5555_5555);
        push_base_pixel(32'h8000_0001);
        quiesce();
    endtask

    // 2x2 images: channel extremes, truncation and channel independence.
    task automatic test_two_by_two_average();
        set_image(4'd1, 4'd1, 4'd1);
        check_reg(bfmc_pkg::REG_LEVEL_COUNT, 4'd1);
        repeat (4) push_base_pixel(32'hFFFF_FFFF);
        repeat (4) push_base_pixel(32'h0000_0000);
        push_base_pixel(32'h0302_0100);
        repeat (3) push_base_pixel(32'h0000_0000);
        repeat (3) push_base_pixel(32'hFFFF_FFFF);
        push_base_pixel(32'h0000_0000);
        push_base_pixel(32'h1234_5678);
        push_base_pixel(32'h9ABC_DEF0);
        push_base_pixel(32'h0F1E_2D3C);
        push_base_pixel(32'hF0E1_D2C3);
        quiesce();
    endtask

    // A write to an unused address keeps the image going; a real write restarts it.
    task automatic test_restart_on_write();
        push_random_pixels(3);
        write_reg(REG_UNUSED, 4'd5);
        push_random_pixels(1);
        push_random_pixels(2);
        write_reg(bfmc_pkg::REG_LEVEL_COUNT, 4'd1);
        push_random_pixels(4);
        quiesce();
    endtask

    // Cascades through every level, image wrap, level count saturation.
    task automatic test_deep_cascade();
        set_image(4'd2, 4'd2, 4'd15);
        in_idle_on = 0;
        out_stall_on = 0;
        push_random_pixels(16);
        in_idle_on = 1;
        out_stall_on = 1;
        push_random_pixels(16);
        set_image(4'd3, 4'd1, 4'd2);
        push_random_pixels(16);
        quiesce();
    endtask

    // Exponents above the maximum saturate; a 1x1 image gives nothing.
    task automatic test_oversize_settings();
        set_image(4'd15, 4'd1, 4'd15);
        check_reg(bfmc_pkg::REG_WIDTH_LOG2, 4'd15);
        push_random_pixels(4);
        set_image(4'd1, 4'd15, 4'd15);
        push_random_pixels(8);
        set_image(4'd0, 4'd15, 4'd15);
        push_random_pixels(2);
        write_reg(bfmc_pkg::REG_HEIGHT_LOG2, 4'd0);
        push_random_pixels(2);
        quiesce();
    endtask

    // Random small images, mostly whole, some cut short by the next setting.
    task automatic test_random_images();
        int unsigned first_pixel;
        int unsigned rounds;
        int unsigned wl;
        int unsigned hl;
        int unsigned lc;
        int unsigned npix;
        first_pixel = pixels_sent;
        rounds = 0;
        while (pixels_sent - first_pixel < 35 && rounds < 20)
        begin
            rounds++;
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            wl = $urandom_range(0, 3);
            hl = $urandom_range(0, 3);
            if (wl + hl > 4)
                hl = 4 - wl;
            case ($urandom_range(0, 9))
                0: lc = 0;
                1: lc = 15;
                default: lc = $urandom_range(1, 12);
            endcase
            set_image(bfmc_pkg::EXP_W'(wl), bfmc_pkg::EXP_W'(hl), bfmc_pkg::EXP_W'(lc));
            npix = 1 << (wl + hl);
            push_random_pixels(npix);
            if ($urandom_range(0, 4) == 0)
                push_random_pixels($urandom_range(1, npix));
        end
        quiesce();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        base_pixel = '0;
        out_ready = 1'b0;
        fail_count = 0;
        pixels_sent = 0;
        beats_predicted = 0;
        beats_checked = 0;
        reg_writes = 0;
        stall_left = 0;
        in_idle_on = 1;
        out_stall_on = 1;
        on_fall_edge = 0;
        cfg_width_log2 = bfmc_pkg::WIDTH_LOG2_RST;
        cfg_height_log2 = bfmc_pkg::HEIGHT_LOG2_RST;
        cfg_level_count = bfmc_pkg::LEVEL_COUNT_RST;
        restart_positions();
        for (int lv = 0; lv <= bfmc_pkg::MAX_LEVELS; lv++)
            left_pixels[lv] = '0;
        for (int i = 0; i < bfmc_pkg::LINE_DEPTH; i++)
            row_pair_sums[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_two_by_two_average();
        test_restart_on_write();
        test_deep_cascade();
        test_oversize_settings();
        test_random_images();
        quiesce();

        $display("Streamed %0d base pixels under %0d register writes;", pixels_sent,
                 reg_writes);
        $display("checked %0d reduced pixels across levels, wraps and restarts.",
                 beats_checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== box_filter_mipmap_chain_core.f =====
+incdir+hw/rtl
hw/rtl/bfmc_pkg.sv
hw/rtl/bfmc_ram.sv
hw/rtl/bfmc_regs.sv
hw/rtl/bfmc_ctrl.sv
hw/rtl/bfmc_datapath.sv
hw/rtl/box_filter_mipmap_chain_core.sv
hw/rtl/bfmc_checker.sv
tb/box_filter_mipmap_chain_core_tb.sv
